FILE: sv/spq_pkg.sv
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned ID_W  = 16;
  localparam int unsigned PRI_W = 8;
  localparam int unsigned REM_W = 16;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned OCC_W = 5;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic {
    KEY_REMAINING = 1'b0,
    KEY_PRIORITY  = 1'b1
  } key_sel_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [REM_W-1:0] rem;
  } entry_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic     push;
    logic     pop;
    key_sel_e key_sel;
    entry_t   ent;
  } cell_ctrl_t;

  function automatic logic [KEY_W-1:0] key_of(entry_t e, key_sel_e sel);
    logic [KEY_W-1:0] k;
    if (sel == KEY_PRIORITY) begin
      k = KEY_W'(e.pri);
    end else begin
      k = e.rem;
    end
    return k;
  endfunction

endpackage

FILE: sv/spq_cell.sv
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occupied_i,
  input  logic               found_i,
  input  spq_pkg::entry_t    left_i,
  input  spq_pkg::entry_t    right_i,
  output logic               found_o,
  output spq_pkg::entry_t    ent_o
);

  spq_pkg::entry_t ent_q;
  spq_pkg::entry_t ent_d;
  logic            cond;

  // insert point: first slot that is free or holds a strictly greater key
  assign cond = !occupied_i ||
                (spq_pkg::key_of(ent_q, ctrl_i.key_sel) >
                 spq_pkg::key_of(ctrl_i.ent, ctrl_i.key_sel));
  assign found_o = found_i || cond;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.push) begin
      if (found_i) begin
        ent_d = left_i;
      end else if (cond) begin
        ent_d = ctrl_i.ent;
      end
    end else if (ctrl_i.pop) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

FILE: sv/stable_priority_queue.sv
// sorted-list priority queue built as a row of shift cells, one record per cell.
// a push compares its key against every cell at once and the cells from the insert
// point onward shift one place toward the tail; a pop shifts every cell one place
// toward the head. equal keys keep arrival order, and the ordering key (remaining
// time or priority) is taken from the key_select register at each push. the block
// takes one item per clock: the whole chain updates in the cycle the item is
// accepted, and the result appears in the output register on the next cycle.
// throughput is bounded only by the output register, so a held result stalls input.
// a push into a full queue leaves it unchanged with status full; a pop from an
// empty queue returns status empty with zero popped fields. write key_select only
// while no item is in flight; entries already held keep their order.
module stable_priority_queue #(
  parameter int unsigned QueueDepth = spq_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_data_i,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [spq_pkg::ID_W-1:0]   process_id_i,
  input  logic [spq_pkg::PRI_W-1:0]  priority_in_i,
  input  logic [spq_pkg::REM_W-1:0]  remaining_in_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [spq_pkg::ID_W-1:0]   popped_id_o,
  output logic [spq_pkg::PRI_W-1:0]  popped_priority_o,
  output logic [spq_pkg::REM_W-1:0]  popped_remaining_o,
  output logic [spq_pkg::ID_W-1:0]   head_id_o,
  output logic [spq_pkg::PRI_W-1:0]  head_priority_o,
  output logic [spq_pkg::REM_W-1:0]  head_remaining_o,
  output logic                       is_empty_o,
  output logic [spq_pkg::OCC_W-1:0]  occupancy_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // key select register, always ready
  spq_pkg::key_sel_e key_sel_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_sel_q <= spq_pkg::KEY_REMAINING;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_sel_q <= spq_pkg::key_sel_e'(cfg_data_i);
    end
  end

  // handshake: input waits only while a result is held downstream
  logic out_valid_q;
  logic accept;
  logic is_push;
  logic full;
  logic empty;
  logic push_ok;
  logic pop_ok;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_push    = (spq_pkg::cmd_e'(command_i) == spq_pkg::CMD_PUSH);
  assign full       = (count_q == CntW'(QueueDepth));
  assign empty      = (count_q == '0);
  assign push_ok    = accept && is_push && !full;
  assign pop_ok     = accept && !is_push && !empty;

  // cell chain
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     new_ent;
  spq_pkg::entry_t     cell_ent [QueueDepth];
  logic [QueueDepth:0] found;

  assign new_ent.id  = process_id_i;
  assign new_ent.pri = priority_in_i;
  assign new_ent.rem = remaining_in_i;

  assign ctrl.push    = push_ok;
  assign ctrl.pop     = pop_ok;
  assign ctrl.key_sel = key_sel_q;
  assign ctrl.ent     = new_ent;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    spq_pkg::entry_t left;
    spq_pkg::entry_t right;
    logic            occupied;

    // slots below the count hold records, the rest are free
    assign occupied = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left = new_ent;
    end else begin : g_mid
      assign left = cell_ent[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = cell_ent[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (occupied),
      .found_i    (found[i]),
      .left_i     (left),
      .right_i    (right),
      .found_o    (found[i+1]),
      .ent_o      (cell_ent[i])
    );
  end

  // occupancy
  always_comb begin
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + CntW'(1);
    end else if (pop_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result assembly, head is the chain's first slot after the update
  spq_pkg::status_e status_d;
  spq_pkg::entry_t  popped_d;
  spq_pkg::entry_t  head_d;

  always_comb begin
    status_d = spq_pkg::ST_DONE;
    popped_d = '0;
    head_d   = empty ? '0 : cell_ent[0];
    if (is_push) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else if (found[1]) begin
        // new record lands at the head
        head_d = new_ent;
      end else begin
        head_d = cell_ent[0];
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        popped_d = cell_ent[0];
        head_d   = (count_q > CntW'(1)) ? cell_ent[1] : '0;
      end
    end
  end

  // output register
  logic                      out_valid_d;
  spq_pkg::status_e          status_q;
  spq_pkg::entry_t           popped_q;
  spq_pkg::entry_t           head_q;
  logic                      is_empty_q;
  logic [spq_pkg::OCC_W-1:0] occ_q;

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      popped_q   <= popped_d;
      head_q     <= head_d;
      is_empty_q <= (count_d == '0);
      occ_q      <= spq_pkg::OCC_W'(count_d);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign popped_id_o        = popped_q.id;
  assign popped_priority_o  = popped_q.pri;
  assign popped_remaining_o = popped_q.rem;
  assign head_id_o          = head_q.id;
  assign head_priority_o    = head_q.pri;
  assign head_remaining_o   = head_q.rem;
  assign is_empty_o         = is_empty_q;
  assign occupancy_o        = occ_q;

endmodule

FILE: sv/spq_checker.sv
module spq_checker #(
  parameter int unsigned QueueDepth = spq_pkg::QUEUE_DEPTH
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic                       cfg_data_i,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       command_i,
  input logic [spq_pkg::ID_W-1:0]   process_id_i,
  input logic [spq_pkg::PRI_W-1:0]  priority_in_i,
  input logic [spq_pkg::REM_W-1:0]  remaining_in_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [1:0]                 status_o,
  input logic [spq_pkg::ID_W-1:0]   popped_id_o,
  input logic [spq_pkg::PRI_W-1:0]  popped_priority_o,
  input logic [spq_pkg::REM_W-1:0]  popped_remaining_o,
  input logic [spq_pkg::ID_W-1:0]   head_id_o,
  input logic [spq_pkg::PRI_W-1:0]  head_priority_o,
  input logic [spq_pkg::REM_W-1:0]  head_remaining_o,
  input logic                       is_empty_o,
  input logic [spq_pkg::OCC_W-1:0]  occupancy_o
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(head_id_o) &&
      $stable(popped_id_o) && $stable(occupancy_o))
    else $error("result changed while stalled");

  // input only waits behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // empty flag agrees with occupancy
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (occupancy_o == '0)))
    else $error("empty flag and occupancy disagree");

  // pop on empty reports nothing popped
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == spq_pkg::ST_EMPTY) |->
      is_empty_o && (popped_id_o == '0) && (popped_remaining_o == '0))
    else $error("bad result for pop on empty queue");

  // rejected push only when full
  a_full_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == spq_pkg::ST_FULL) |->
      (occupancy_o == spq_pkg::OCC_W'(QueueDepth)) && !is_empty_o)
    else $error("push rejected while not full");

endmodule

bind stable_priority_queue spq_checker #(.QueueDepth(QueueDepth)) u_spq_checker (.*);

FILE: dv/stable_priority_queue_tb.sv
module stable_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 20;
  localparam int unsigned RANDOM_PHASES  = 5;
  localparam int unsigned PHASE_ITEMS    = 250;

  // one command for the queue as the driver offers it
  typedef struct packed {
    spq_pkg::cmd_e   cmd;
    spq_pkg::entry_t rec;
  } sched_op_t;

  // what the queue should answer for one item
  typedef struct packed {
    spq_pkg::status_e          status;
    spq_pkg::entry_t           popped;
    spq_pkg::entry_t           head;
    logic                      is_empty;
    logic [spq_pkg::OCC_W-1:0] occupancy;
  } sched_result_t;

  logic                        clk_i              = 1'b0;
  logic                        rst_ni             = 1'b0;
  logic                        cfg_valid_i        = 1'b0;
  logic                        cfg_ready_o;
  logic                        cfg_data_i         = 1'b0;
  logic                        in_valid_i         = 1'b0;
  logic                        in_stall_o;
  logic                        command_i          = 1'b0;
  logic [spq_pkg::ID_W-1:0]    process_id_i       = '0;
  logic [spq_pkg::PRI_W-1:0]   priority_in_i      = '0;
  logic [spq_pkg::REM_W-1:0]   remaining_in_i     = '0;
  logic                        out_valid_o;
  logic                        out_stall_i        = 1'b0;
  logic [1:0]                  status_o;
  logic [spq_pkg::ID_W-1:0]    popped_id_o;
  logic [spq_pkg::PRI_W-1:0]   popped_priority_o;
  logic [spq_pkg::REM_W-1:0]   popped_remaining_o;
  logic [spq_pkg::ID_W-1:0]    head_id_o;
  logic [spq_pkg::PRI_W-1:0]   head_priority_o;
  logic [spq_pkg::REM_W-1:0]   head_remaining_o;
  logic                        is_empty_o;
  logic [spq_pkg::OCC_W-1:0]   occupancy_o;

  stable_priority_queue u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .process_id_i       (process_id_i),
    .priority_in_i      (priority_in_i),
    .remaining_in_i     (remaining_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .popped_id_o        (popped_id_o),
    .popped_priority_o  (popped_priority_o),
    .popped_remaining_o (popped_remaining_o),
    .head_id_o          (head_id_o),
    .head_priority_o    (head_priority_o),
    .head_remaining_o   (head_remaining_o),
    .is_empty_o         (is_empty_o),
    .occupancy_o        (occupancy_o)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // shadow copy of the sorted queue
  spq_pkg::entry_t   held_recs [spq_pkg::QUEUE_DEPTH];
  int unsigned       held_cnt;
  spq_pkg::key_sel_e order_key;

  sched_op_t     pending_ops[$];
  sched_result_t expected_results[$];
  sched_op_t     cur_op;
  sched_result_t predicted;
  sched_result_t want;

  int unsigned ops_queued;
  int unsigned items_in;
  int unsigned results_seen;
  int unsigned mismatch_cnt;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned rx_count;
  int unsigned next_hold_at;
  int unsigned long_holds;
  int unsigned stuck_cycles;
  int unsigned key_writes;
  int unsigned n_push_ok, n_push_full, n_pop_ok, n_pop_empty;
  bit          quiet;

  initial begin
    held_cnt     = 0;
    order_key    = spq_pkg::KEY_REMAINING;
    ops_queued   = 0;
    items_in     = 0;
    results_seen = 0;
    mismatch_cnt = 0;
    send_gap     = 0;
    stall_left   = 0;
    hold_left    = 0;
    rx_count     = 0;
    next_hold_at = 150;
    long_holds   = 0;
    stuck_cycles = 0;
    key_writes   = 0;
    n_push_ok    = 0;
    n_push_full  = 0;
    n_pop_ok     = 0;
    n_pop_empty  = 0;
    quiet        = 1'b0;
  end

  function automatic logic [15:0] rank_of(spq_pkg::entry_t e);
    return (order_key == spq_pkg::KEY_PRIORITY) ? {8'h00, e.pri} : e.rem;
  endfunction

  // apply one command to the shadow queue and return the expected answer
  function automatic sched_result_t sched_step(spq_pkg::cmd_e cmd, spq_pkg::entry_t rec);
    sched_result_t r;
    int unsigned   pos;
    int unsigned   i;
    r = '0;
    r.status = spq_pkg::ST_DONE;
    if (cmd == spq_pkg::CMD_PUSH) begin
      if (held_cnt >= spq_pkg::QUEUE_DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // stable insert: skip every record whose key is not above the new one
        pos = 0;
        while (pos < held_cnt && rank_of(held_recs[pos]) <= rank_of(rec)) pos++;
        for (i = held_cnt; i > pos; i--) held_recs[i] = held_recs[i-1];
        held_recs[pos] = rec;
        held_cnt++;
      end
    end else begin
      if (held_cnt == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.popped = held_recs[0];
        for (i = 1; i < held_cnt; i++) held_recs[i-1] = held_recs[i];
        held_cnt--;
      end
    end
    if (held_cnt > 0) r.head = held_recs[0];
    r.is_empty  = (held_cnt == 0);
    r.occupancy = spq_pkg::OCC_W'(held_cnt);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_op(spq_pkg::cmd_e cmd, logic [15:0] id, logic [7:0] pri,
                        logic [15:0] rem);
    sched_op_t op;
    op.cmd     = cmd;
    op.rec.id  = id;
    op.rec.pri = pri;
    op.rec.rem = rem;
    pending_ops.push_back(op);
    ops_queued++;
  endtask

  // small key ranges most of the time so that ties are common
  task automatic add_random_ops(int unsigned n, int unsigned push_pct);
    int unsigned k;
    int unsigned roll;
    logic [7:0]  pri;
    logic [15:0] rem;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        pri = 8'($urandom);
        rem = 16'($urandom);
      end else if (roll < 15) begin
        pri = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        rem = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      end else begin
        pri = 8'($urandom_range(0, 7));
        rem = 16'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 99) < push_pct) begin
        add_op(spq_pkg::CMD_PUSH, 16'($urandom), pri, rem);
      end else begin
        // pop carries noise in its unused payload
        add_op(spq_pkg::CMD_POP, 16'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic write_key_select(spq_pkg::key_sel_e sel);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sel;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    order_key = sel;
    key_writes++;
  endtask

  // everything handed over has been accepted and answered
  task automatic wait_idle();
    do @(posedge clk_i);
    while (items_in != ops_queued || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, int unsigned n, logic [15:0] got,
                                 logic [15:0] want_v);
    if (mismatch_cnt < MAX_REPORTS) begin
      $display("mismatch at result %0d: %s got %h want %h", n, what, got, want_v);
    end
    mismatch_cnt++;
  endtask

  // driver: holds the item while stalled, then loads the next one after its gap
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted = sched_step(cur_op.cmd, cur_op.rec);
        expected_results.push_back(predicted);
        case (predicted.status)
          spq_pkg::ST_FULL:  n_push_full++;
          spq_pkg::ST_EMPTY: n_pop_empty++;
          default: begin
            if (cur_op.cmd == spq_pkg::CMD_PUSH) n_push_ok++;
            else n_pop_ok++;
          end
        endcase
        items_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0 || pending_ops.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid_i <= 1'b0;
        end else begin
          cur_op          = pending_ops.pop_front();
          in_valid_i     <= 1'b1;
          command_i      <= cur_op.cmd;
          process_id_i   <= cur_op.rec.id;
          priority_in_i  <= cur_op.rec.pri;
          remaining_in_i <= cur_op.rec.rem;
          send_gap        = quiet ? 0 : idle_len();
        end
      end
    end
  end

  // receiver: random stalls plus a few long hold-offs that back the block up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) rx_count++;
      if (hold_left == 0 && rx_count >= next_hold_at) begin
        hold_left    = $urandom_range(80, 160);
        next_hold_at = next_hold_at + 500;
        long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left   = quiet ? 0 : idle_len();
      end
    end
  end

  // monitor: every result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", results_seen, '0, '0);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", results_seen, 16'(status_o), 16'(want.status));
        if (popped_id_o !== want.popped.id)
          report_mismatch("popped_id", results_seen, popped_id_o, want.popped.id);
        if (popped_priority_o !== want.popped.pri)
          report_mismatch("popped_priority", results_seen, 16'(popped_priority_o),
                          16'(want.popped.pri));
        if (popped_remaining_o !== want.popped.rem)
          report_mismatch("popped_remaining", results_seen, popped_remaining_o,
                          want.popped.rem);
        if (head_id_o !== want.head.id)
          report_mismatch("head_id", results_seen, head_id_o, want.head.id);
        if (head_priority_o !== want.head.pri)
          report_mismatch("head_priority", results_seen, 16'(head_priority_o),
                          16'(want.head.pri));
        if (head_remaining_o !== want.head.rem)
          report_mismatch("head_remaining", results_seen, head_remaining_o, want.head.rem);
        if (is_empty_o !== want.is_empty)
          report_mismatch("is_empty", results_seen, 16'(is_empty_o), 16'(want.is_empty));
        if (occupancy_o !== want.occupancy)
          report_mismatch("occupancy", results_seen, 16'(occupancy_o), 16'(want.occupancy));
      end
    end
  end

  // watchdog: too long without any handshake on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("stable_priority_queue_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    int unsigned push_bias [RANDOM_PHASES];
    push_bias = '{55, 75, 25, 60, 50};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: order by remaining time
    write_key_select(spq_pkg::KEY_REMAINING);
    add_op(spq_pkg::CMD_POP, 16'h1234, 8'h12, 16'h3456);   // pop on empty queue
    add_op(spq_pkg::CMD_PUSH, 16'hFFFF, 8'hFF, 16'hFFFF);  // all-ones record
    add_op(spq_pkg::CMD_PUSH, 16'h0000, 8'h00, 16'h0000);  // all-zeros record goes to head
    add_op(spq_pkg::CMD_PUSH, 16'h0001, 8'h05, 16'h0000);  // tie at the head, stays behind
    add_op(spq_pkg::CMD_PUSH, 16'h0002, 8'h00, 16'hFFFF);  // tie at the tail, stays behind
    add_op(spq_pkg::CMD_POP, 16'h0000, 8'h00, 16'h0000);
    for (k = 0; k < 13; k++) begin
      // descending keys, each lands just behind the zero-key record
      add_op(spq_pkg::CMD_PUSH, 16'(16'h0100 + k), 8'(k * 19), 16'(16'h8000 - k * 1000));
    end
    add_op(spq_pkg::CMD_PUSH, 16'hBEEF, 8'h00, 16'h0000);  // queue full, rejected
    add_op(spq_pkg::CMD_POP, 16'hFFFF, 8'hFF, 16'hFFFF);
    add_op(spq_pkg::CMD_POP, 16'hFFFF, 8'hFF, 16'hFFFF);
    wait_idle();

    // key change with records held: old order stays, new pushes use priority
    write_key_select(spq_pkg::KEY_PRIORITY);
    add_op(spq_pkg::CMD_PUSH, 16'hA5A5, 8'h80, 16'h0001);
    add_op(spq_pkg::CMD_PUSH, 16'h5A5A, 8'h00, 16'hFFFF);
    add_op(spq_pkg::CMD_POP, 16'h0000, 8'h00, 16'h0000);
    wait_idle();

    // random phases, alternating key, a different push bias in each, one phase without idling
    for (k = 0; k < RANDOM_PHASES; k++) begin
      write_key_select((k % 2 == 0) ? spq_pkg::KEY_REMAINING : spq_pkg::KEY_PRIORITY);
      quiet = (k == 3);
      add_random_ops(PHASE_ITEMS, push_bias[k]);
      wait_idle();
      quiet = 1'b0;
    end

    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report_mismatch("missing result", results_seen, '0, '0);
    end

    $display("covered %0d items: %0d pushes stored, %0d pushes on a full queue,",
             items_in, n_push_ok, n_push_full);
    $display("  %0d pops, %0d pops on an empty queue, key written %0d times,",
             n_pop_ok, n_pop_empty, key_writes);
    $display("  %0d long receiver hold-offs, %0d mismatches", long_holds, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("stable_priority_queue_tb: PASS");
    end else begin
      $display("stable_priority_queue_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: stable_priority_queue.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
sv/spq_checker.sv
dv/stable_priority_queue_tb.sv
